// File: design/sgea_pkg.sv
// ---------------------------------------------------------------------------
// sgea_pkg: shared definitions for the sensor gain/exposure apply block
// Item and register codes, result entry type and the 2^(k/32) Q30 table.
// ---------------------------------------------------------------------------
package sgea_pkg;

  localparam logic [1:0] OP_SET_GAIN     = 2'd0;
  localparam logic [1:0] OP_SET_EXPOSURE = 2'd1;
  localparam logic [1:0] OP_FRAME_TICK   = 2'd2;

  localparam logic [2:0] REG_WDR_MODE           = 3'd0;
  localparam logic [2:0] REG_GAIN_DELAY         = 3'd1;
  localparam logic [2:0] REG_EXPOSURE_DELAY     = 3'd2;
  localparam logic [2:0] REG_MAX_EXPOSURE_LINES = 3'd3;
  localparam logic [2:0] REG_MAX_GAIN_CODE      = 3'd4;

  localparam logic KIND_GAIN     = 1'b0;
  localparam logic KIND_EXPOSURE = 1'b1;

  localparam logic [15:0] MAX_EXPOSURE_LINES_RESET = 16'd3112;
  localparam logic [15:0] MAX_GAIN_CODE_RESET      = 16'd3698;

  // integer part at which the Q30 table shifted down to Q8 saturates
  localparam logic [12:0] GAIN_INT_LIMIT = 13'd22;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic        last;
  } result_t;

  function automatic logic [31:0] exp2_q30(input logic [5:0] k);
    logic [31:0] v;
    case (k)
      6'd0:  v = 32'd1073741824;
      6'd1:  v = 32'd1097253708;
      6'd2:  v = 32'd1121280436;
      6'd3:  v = 32'd1145833280;
      6'd4:  v = 32'd1170923762;
      6'd5:  v = 32'd1196563654;
      6'd6:  v = 32'd1222764986;
      6'd7:  v = 32'd1249540052;
      6'd8:  v = 32'd1276901417;
      6'd9:  v = 32'd1304861917;
      6'd10: v = 32'd1333434672;
      6'd11: v = 32'd1362633090;
      6'd12: v = 32'd1392470869;
      6'd13: v = 32'd1422962010;
      6'd14: v = 32'd1454120821;
      6'd15: v = 32'd1485961921;
      6'd16: v = 32'd1518500250;
      6'd17: v = 32'd1551751076;
      6'd18: v = 32'd1585730000;
      6'd19: v = 32'd1620452965;
      6'd20: v = 32'd1655936265;
      6'd21: v = 32'd1692196547;
      6'd22: v = 32'd1729250827;
      6'd23: v = 32'd1767116489;
      6'd24: v = 32'd1805811301;
      6'd25: v = 32'd1845353420;
      6'd26: v = 32'd1885761398;
      6'd27: v = 32'd1927054196;
      6'd28: v = 32'd1969251188;
      6'd29: v = 32'd2012372174;
      6'd30: v = 32'd2056437387;
      6'd31: v = 32'd2101467502;
      6'd32: v = 32'd2147483648;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/sensor_gain_exposure_apply.sv
// ---------------------------------------------------------------------------
// sensor_gain_exposure_apply: delayed sensor gain and exposure writes
// Converts log2 gain and exposure requests into sensor register writes
// that are released by frame ticks after a programmable frame delay.
// ---------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_ready with operation, gain_log2,
//   exposure_long and exposure_short. Sensor writes leave on
//   result_valid/result_ready as write_kind, write_value, last_write.
//   Registers are written through cfg_write_enable/cfg_index/cfg_data;
//   the user must write them only while idle; the block does not enforce it.
//   An accepted item passes the input and second registers before its
//   writes enter the result queue. Throughput: one item per cycle while
//   the update stage is not held. The input register feeds the table
//   lookup and interpolation multiplier; the second register feeds the
//   rounding shift, clamps and the history/pending state update. A tick
//   makes up to two writes, each one output transfer.
//   Stall: a 4-entry result queue sits before the output; the update stage
//   holds while fewer than two entries are free, and backpressure reaches
//   item_ready through the two stage registers.
//   Reset: histories and pending counters clear, registers take their
//   reset values, and the queue empties.
// ---------------------------------------------------------------------------
module sensor_gain_exposure_apply #(
  parameter int FRACTION_BITS = 8,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  operation,
  input  logic [12:0] gain_log2,
  input  logic [23:0] exposure_long,
  input  logic [23:0] exposure_short,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        write_kind,
  output logic [15:0] write_value,
  output logic        last_write,
  input  logic        cfg_write_enable,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [16:0] FRAC_ONE = 17'd1 << FRACTION_BITS;
  localparam logic [15:0] FRAC_MASK = 16'(FRAC_ONE - 17'd1);
  localparam bit ROUND = (FRACTION_BITS > 5);

  // configuration
  logic        wdr_mode;
  logic [1:0]  gain_delay;
  logic [1:0]  exposure_delay;
  logic [15:0] max_exposure_lines;
  logic [15:0] max_gain_code;

  // state
  logic [15:0] gain_history [HISTORY_DEPTH];
  logic [15:0] long_exposure_history [HISTORY_DEPTH];
  logic [15:0] short_exposure_history [HISTORY_DEPTH];
  logic [2:0]  gain_pending;
  logic [2:0]  exposure_pending;

  // stage A
  logic        a_valid;
  logic [1:0]  a_op;
  logic [12:0] a_gain;
  logic [23:0] a_long;
  logic [23:0] a_short;

  // stage B
  logic        b_valid;
  logic [1:0]  b_op;
  logic        b_sat;
  logic [4:0]  b_sh;
  logic [31:0] b_base;
  logic [25:0] b_interp;
  logic [15:0] b_long;
  logic [15:0] b_short;

  // result queue
  sgea_pkg::result_t fifo [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;

  logic a_adv;
  logic b_adv;
  logic pop;

  always_comb begin
    pop = (count != 3'd0) && result_ready;
    b_adv = b_valid && (count <= 3'd2);
    a_adv = a_valid && (!b_valid || b_adv);
    item_ready = !a_valid || a_adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wdr_mode <= 1'b0;
      gain_delay <= 2'd0;
      exposure_delay <= 2'd0;
      max_exposure_lines <= sgea_pkg::MAX_EXPOSURE_LINES_RESET;
      max_gain_code <= sgea_pkg::MAX_GAIN_CODE_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        sgea_pkg::REG_WDR_MODE:           wdr_mode <= cfg_data[0];
        sgea_pkg::REG_GAIN_DELAY:         gain_delay <= cfg_data[1:0];
        sgea_pkg::REG_EXPOSURE_DELAY:     exposure_delay <= cfg_data[1:0];
        sgea_pkg::REG_MAX_EXPOSURE_LINES: max_exposure_lines <= cfg_data;
        sgea_pkg::REG_MAX_GAIN_CODE:      max_gain_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage A: table lookup and interpolation ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_ready) begin
      a_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      a_op <= operation;
      a_gain <= gain_log2;
      a_long <= exposure_long;
      a_short <= exposure_short;
    end
  end

  logic [12:0] a_ip;
  logic        a_sat;
  logic [4:0]  a_sh;
  logic [15:0] a_fract;
  logic [31:0] a_base;
  logic [25:0] a_interp;

  assign a_ip = a_gain >> FRACTION_BITS;
  assign a_sat = (a_ip >= sgea_pkg::GAIN_INT_LIMIT);
  assign a_sh = 5'(5'd22 - a_ip[4:0]);
  assign a_fract = {3'b000, a_gain} & FRAC_MASK;

  generate
    if (FRACTION_BITS <= 5) begin : g_direct
      localparam int UP = 5 - FRACTION_BITS;
      logic [4:0] idx;
      assign idx = 5'(a_fract << UP);
      assign a_base = sgea_pkg::exp2_q30({1'b0, idx});
      assign a_interp = '0;
    end else begin : g_interp
      localparam int D = FRACTION_BITS - 5;
      localparam int PW = 26 + D;
      logic [4:0]    idx;
      logic [D-1:0]  lf;
      logic [31:0]   hi;
      logic [25:0]   diff;
      logic [PW-1:0] prod;
      assign idx = 5'(a_fract >> D);
      assign lf = a_fract[D-1:0];
      assign a_base = sgea_pkg::exp2_q30({1'b0, idx});
      assign hi = sgea_pkg::exp2_q30(6'({1'b0, idx} + 6'd1));
      assign diff = 26'(hi - a_base);
      assign prod = PW'(diff) * PW'(lf);
      assign a_interp = 26'(prod >> D);
    end
  endgenerate

  logic [23:0] a_long_lines;
  logic [23:0] a_short_lines;
  logic [23:0] lng;
  logic [23:0] sht;
  logic [15:0] a_long_sat;
  logic [15:0] a_short_sat;

  assign a_long_lines = a_long >> FRACTION_BITS;
  assign a_short_lines = a_short >> FRACTION_BITS;

  always_comb begin
    lng = a_long_lines;
    sht = a_short_lines;
    if (!wdr_mode) begin
      if (lng > {8'd0, max_exposure_lines}) begin
        lng = {8'd0, max_exposure_lines};
      end
      if (lng == 24'd0) begin
        lng = 24'd1;
      end
    end else begin
      if (sht == 24'd0) begin
        sht = 24'd1;
      end
    end
    a_long_sat = (lng > 24'h00FFFF) ? 16'hFFFF : lng[15:0];
    a_short_sat = (sht > 24'h00FFFF) ? 16'hFFFF : sht[15:0];
  end

  // ---------------- stage B: rounding, clamps and state update -------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_valid || b_adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_op <= a_op;
      b_sat <= a_sat;
      b_sh <= a_sh;
      b_base <= a_base;
      b_interp <= a_interp;
      b_long <= a_long_sat;
      b_short <= a_short_sat;
    end
  end

  logic [32:0] b_round;
  logic [32:0] b_sum;
  logic [32:0] b_res;
  logic [15:0] b_code;

  always_comb begin
    b_round = ROUND ? (33'd1 << (b_sh - 5'd1)) : 33'd0;
    b_sum = 33'(b_base) + 33'(b_interp) + b_round;
    b_res = b_sum >> b_sh;
    if (b_sat || (b_res > 33'(max_gain_code))) begin
      b_code = max_gain_code;
    end else begin
      b_code = b_res[15:0];
    end
  end

  logic [IW-1:0] gain_sel;
  logic [IW-1:0] exposure_sel;
  logic          gain_emit;
  logic          exposure_emit;
  logic          is_tick;
  sgea_pkg::result_t r0;
  sgea_pkg::result_t r1;
  logic [1:0]    push_n;

  always_comb begin
    gain_sel = (int'(gain_delay) > HISTORY_DEPTH - 1) ?
               IW'(HISTORY_DEPTH - 1) : IW'(gain_delay);
    exposure_sel = (int'(exposure_delay) > HISTORY_DEPTH - 1) ?
                   IW'(HISTORY_DEPTH - 1) : IW'(exposure_delay);
    is_tick = (b_op == sgea_pkg::OP_FRAME_TICK);
    gain_emit = (gain_pending != 3'd0);
    exposure_emit = (exposure_pending != 3'd0) && !wdr_mode;

    r1.kind = sgea_pkg::KIND_EXPOSURE;
    r1.value = long_exposure_history[exposure_sel];
    r1.last = 1'b1;
    if (gain_emit) begin
      r0.kind = sgea_pkg::KIND_GAIN;
      r0.value = gain_history[gain_sel];
      r0.last = !exposure_emit;
    end else begin
      r0 = r1;
    end
    push_n = (b_adv && is_tick) ? (2'(gain_emit) + 2'(exposure_emit)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        gain_history[i] <= 16'd0;
        long_exposure_history[i] <= 16'd0;
        short_exposure_history[i] <= 16'd0;
      end
      gain_pending <= 3'd0;
      exposure_pending <= 3'd0;
    end else if (b_adv) begin
      case (b_op)
        sgea_pkg::OP_SET_GAIN: begin
          if (gain_history[0] != b_code) begin
            gain_history[0] <= b_code;
            gain_pending <= 3'(gain_delay) + 3'd1;
          end
        end
        sgea_pkg::OP_SET_EXPOSURE: begin
          if ((long_exposure_history[0] != b_long) ||
              (short_exposure_history[0] != b_short)) begin
            long_exposure_history[0] <= b_long;
            short_exposure_history[0] <= b_short;
            exposure_pending <= 3'(exposure_delay) + 3'd1;
          end
        end
        sgea_pkg::OP_FRAME_TICK: begin
          if (gain_pending != 3'd0) begin
            gain_pending <= gain_pending - 3'd1;
          end
          if (exposure_pending != 3'd0) begin
            exposure_pending <= exposure_pending - 3'd1;
          end
          for (int i = 1; i < HISTORY_DEPTH; i++) begin
            gain_history[i] <= gain_history[i-1];
            long_exposure_history[i] <= long_exposure_history[i-1];
            short_exposure_history[i] <= short_exposure_history[i-1];
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- result queue ----------------
  assign count_next = count + 3'(push_n) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= r0;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + 2'd1] <= r1;
    end
  end

  assign result_valid = (count != 3'd0);
  assign write_kind = fifo[rd_ptr].kind;
  assign write_value = fifo[rd_ptr].value;
  assign last_write = fifo[rd_ptr].last;

endmodule
